[rtl/ptd_pkg.sv]
// Package for the periodic task dispatcher: request/response structs,
// request and status codes, shared constants. No dependencies.
`default_nettype none
package ptd_pkg;
   localparam int SLOT_COUNT_DEF = 16;
   localparam logic [14:0] MISS_MAX = 15'h7FFF;

   typedef enum logic [2:0] {
      REQ_ADD = 3'd0, REQ_MODIFY = 3'd1, REQ_PAUSE = 3'd2, REQ_FREE = 3'd3,
      REQ_DISPATCH = 3'd4, REQ_QUERY_ID = 3'd5, REQ_QUERY_TOT = 3'd6, REQ_NONE = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0, ST_FAIL = 2'd1, ST_IDLE = 2'd2, ST_DISPATCHED = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [31:0]        now_time;
      logic [31:0]        finish_time;
      logic [14:0]        task_id;
      logic [3:0]         slot_index;
      logic [31:0]        new_arrival;
      logic signed [15:0] new_priority;
      logic [31:0]        new_period;
      logic signed [15:0] new_deadline;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  chosen_slot;
      logic [14:0] chosen_id;
      logic [31:0] sleep_ticks;
      logic [14:0] miss_count;
      logic [31:0] first_run_time;
      logic [31:0] idle_total;
   } rsp_type_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request
      logic scan;    // evaluate current slot
      logic commit;  // apply update, emit result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;    // scan index at final slot
   } sts_type;
endpackage
`default_nettype wire

[rtl/periodic_task_dispatcher.sv]
// Top level of the periodic task dispatcher: controller plus datapath.
// Depends on ptd_pkg, ptd_ctrl, ptd_datapath.
//
// Usage: drive req with a request and raise start while busy is low; the
// item is taken on that edge. busy then stays high while the table is scanned
// one slot per cycle and then during the commit step. The result is registered
// at the end of the commit step and appears on rsp with rsp_valid high for
// exactly one cycle; it is taken at the edge that ends that cycle, and the next
// item may be accepted at that same edge, as busy is already low; no new item
// is taken before the slot scan and commit of the last one are done.
// The receiver cannot stall; it must take rsp whenever
// rsp_valid is high.
// csr_we/csr_wdata write priority_mode (1 = highest priority, 0 = earliest
// deadline); write only while idle. Synchronous reset frees all slots, sets
// priority_mode to 1, clears totals and arms the idle report.
`default_nettype none
module periodic_task_dispatcher import ptd_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type_type req_item,
   output logic         rsp_valid,
   output rsp_type_type rsp_item,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   logic    mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b1;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   ptd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .sts(sts)
   );

   ptd_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
      .clock(clock), .reset(reset), .mode(mode_ff), .cmd(cmd), .sts(sts),
      .req(req_item), .rsp(rsp_item), .rsp_valid(rsp_valid)
   );
endmodule
`default_nettype wire

[rtl/ptd_ctrl.sv]
// Controller for the periodic task dispatcher: sequences load, slot scan
// and commit. Depends on ptd_pkg.
`default_nettype none
module ptd_ctrl import ptd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_SCAN = 3'b010, S_COMMIT = 3'b100
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

[rtl/ptd_datapath.sv]
// Datapath for the periodic task dispatcher: slot table, one-slot-per-cycle
// scan unit, commit logic and result register. Depends on ptd_pkg.
`default_nettype none
module ptd_datapath import ptd_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   mode,
   input  wire cmd_type cmd,
   output sts_type     sts,
   input  wire req_type_type req,
   output rsp_type_type rsp,
   output logic        rsp_valid
);
   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [SLOT_COUNT-1:0]  used_ff, paused_ff;
   logic [14:0]            id_ff     [SLOT_COUNT];
   logic [31:0]            arr_ff    [SLOT_COUNT];
   logic [31:0]            per_ff    [SLOT_COUNT];
   logic [15:0]            pri_ff    [SLOT_COUNT];
   logic [15:0]            dl_ff     [SLOT_COUNT];
   logic [14:0]            miss_ff   [SLOT_COUNT];

   req_type_type           r_ff;
   logic [IW-1:0]          idx_ff;
   logic                   best_v_ff, near_v_ff, free_v_ff, find_v_ff;
   logic [IW-1:0]          best_ff, free_ff, find_ff;
   logic signed [15:0]     bpri_ff;
   logic [31:0]            bkey_ff, narr_ff;
   logic [15:0]            tot_ff;
   logic [31:0]            stamp_ff, isum_ff;
   logic                   started_ff, armed_ff;

   // current slot view
   logic        c_used, c_elig, c_fut;
   logic [31:0] c_key, c_arr;
   logic [15:0] tot_add;
   logic        idx_ok;
   always_comb begin
      c_used = used_ff[idx_ff];
      c_arr  = arr_ff[idx_ff];
      c_elig = c_used && !paused_ff[idx_ff] && (c_arr <= r_ff.now_time);
      c_fut  = c_used && (c_arr > r_ff.now_time);
      c_key  = (c_arr + {{16{dl_ff[idx_ff][15]}}, dl_ff[idx_ff]} - r_ff.now_time)
               ^ 32'h8000_0000;
      tot_add = tot_ff + (c_used ? {1'b0, miss_ff[idx_ff]} : 16'd0);
      if (tot_add[15]) tot_add = {1'b0, MISS_MAX};
   end
   assign sts.last = (idx_ff == IW'(SLOT_COUNT - 1));
   assign idx_ok = ({3'b000, r_ff.slot_index} < 7'(SLOT_COUNT));

   // commit values for the chosen task
   logic [31:0] n_arr, n_d;
   logic [31:0] sleep;
   always_comb begin
      n_arr = arr_ff[best_ff] + per_ff[best_ff];
      n_d   = n_arr + {{16{dl_ff[best_ff][15]}}, dl_ff[best_ff]} - r_ff.finish_time;
      sleep = near_v_ff ? (narr_ff - r_ff.now_time) : 32'd0;
   end

   rsp_type_type rsp_in;
   always_comb begin
      rsp_in = '0;
      rsp_in.first_run_time = stamp_ff;
      rsp_in.idle_total = isum_ff;
      case (r_ff.req_type)
         REQ_ADD: begin
            if (free_v_ff) rsp_in.chosen_slot = 4'(free_ff);
            else rsp_in.status = ST_FAIL;
         end
         REQ_MODIFY: begin
            if (find_v_ff) rsp_in.chosen_slot = 4'(find_ff);
            else rsp_in.status = ST_FAIL;
         end
         REQ_DISPATCH: begin
            if (!started_ff) rsp_in.first_run_time = r_ff.now_time;
            if (best_v_ff) begin
               rsp_in.status = ST_DISPATCHED;
               rsp_in.chosen_slot = 4'(best_ff);
               rsp_in.chosen_id = id_ff[best_ff];
            end else begin
               rsp_in.status = ST_IDLE;
               if (armed_ff) begin
                  rsp_in.sleep_ticks = sleep;
                  rsp_in.idle_total = isum_ff + sleep;
               end
            end
         end
         REQ_QUERY_ID: begin
            if (find_v_ff) begin
               rsp_in.chosen_slot = 4'(find_ff);
               rsp_in.miss_count = miss_ff[find_ff];
            end else rsp_in.status = ST_FAIL;
         end
         REQ_QUERY_TOT: rsp_in.miss_count = tot_ff[14:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         paused_ff  <= '0;
         started_ff <= 1'b0;
         armed_ff   <= 1'b1;
         stamp_ff   <= '0;
         isum_ff    <= '0;
         rsp_valid  <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            miss_ff[i] <= '0;
            arr_ff[i]  <= '0;
         end
      end else begin
         rsp_valid <= cmd.commit;
         if (cmd.load) begin
            idx_ff    <= '0;
            best_v_ff <= 1'b0;
            near_v_ff <= 1'b0;
            free_v_ff <= 1'b0;
            find_v_ff <= 1'b0;
            tot_ff    <= '0;
         end
         if (cmd.scan) begin
            if (!sts.last) idx_ff <= idx_ff + 1'b1;
            tot_ff <= tot_add;
            if (!c_used && !free_v_ff) begin
               free_v_ff <= 1'b1;
               free_ff <= idx_ff;
            end
            if (c_used && id_ff[idx_ff] == r_ff.task_id && !find_v_ff) begin
               find_v_ff <= 1'b1;
               find_ff <= idx_ff;
            end
            if (c_elig) begin
               if (mode) begin
                  if (!best_v_ff || $signed(pri_ff[idx_ff]) > bpri_ff) begin
                     best_v_ff <= 1'b1;
                     best_ff <= idx_ff;
                     bpri_ff <= $signed(pri_ff[idx_ff]);
                  end
               end else if (!best_v_ff || c_key < bkey_ff) begin
                  best_v_ff <= 1'b1;
                  best_ff <= idx_ff;
                  bkey_ff <= c_key;
               end
            end
            if (c_fut && (!near_v_ff || c_arr < narr_ff)) begin
               near_v_ff <= 1'b1;
               narr_ff <= c_arr;
            end
         end
         if (cmd.commit) begin
            case (r_ff.req_type)
               REQ_ADD: begin
                  if (free_v_ff) begin
                     used_ff[free_ff] <= 1'b1;
                     id_ff[free_ff]   <= r_ff.task_id;
                     arr_ff[free_ff]  <= r_ff.new_arrival;
                     per_ff[free_ff]  <= r_ff.new_period;
                     pri_ff[free_ff]  <= r_ff.new_priority;
                     dl_ff[free_ff]   <= r_ff.new_deadline;
                  end
               end
               REQ_MODIFY: begin
                  if (find_v_ff) begin
                     arr_ff[find_ff] <= r_ff.new_arrival;
                     per_ff[find_ff] <= r_ff.new_period;
                     pri_ff[find_ff] <= r_ff.new_priority;
                     dl_ff[find_ff]  <= r_ff.new_deadline;
                  end
               end
               REQ_PAUSE: begin
                  if (idx_ok) paused_ff[IW'(r_ff.slot_index)] <= 1'b1;
               end
               REQ_FREE: begin
                  if (idx_ok) begin
                     used_ff[IW'(r_ff.slot_index)]   <= 1'b0;
                     paused_ff[IW'(r_ff.slot_index)] <= 1'b0;
                     miss_ff[IW'(r_ff.slot_index)]   <= '0;
                     arr_ff[IW'(r_ff.slot_index)]    <= '0;
                  end
               end
               REQ_DISPATCH: begin
                  if (!started_ff) begin
                     started_ff <= 1'b1;
                     stamp_ff <= r_ff.now_time;
                  end
                  if (best_v_ff) begin
                     arr_ff[best_ff] <= n_arr;
                     if (n_d[31] && miss_ff[best_ff] != MISS_MAX)
                        miss_ff[best_ff] <= miss_ff[best_ff] + 1'b1;
                     armed_ff <= 1'b1;
                  end else if (armed_ff) begin
                     armed_ff <= 1'b0;
                     isum_ff <= isum_ff + sleep;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      if (cmd.commit) rsp <= rsp_in;
   end
endmodule
`default_nettype wire
